// ===== src/ctq_pkg.sv =====
// Shared types and constants for the connection idle timeout queue.
`timescale 1ns / 1ps
package ctq_pkg;

	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int SLOT_W   = 6;
	localparam int LINK_W   = 7;
	localparam int TICK_W   = 32;
	localparam int BUMP_W   = 16;
	localparam int DATA_W   = TICK_W + 1;

	localparam logic [LINK_W-1:0] LINK_END   = {LINK_W{1'b1}};
	localparam logic [BUMP_W-1:0] BUMP_RESET = BUMP_W'(15);

	typedef enum logic [2:0] {
		CMD_INSERT    = 3'd0,
		CMD_TOUCH     = 3'd1,
		CMD_CLOSE     = 3'd2,
		CMD_TICK      = 3'd3,
		CMD_CLOSE_ALL = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		EV_DONE    = 2'd0,
		EV_EXPIRED = 2'd1,
		EV_PING    = 2'd2,
		EV_REJECT  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_CHK,
		S_UNL,
		S_APP1,
		S_APP2,
		S_FIN
	} state_t;

	typedef struct packed {
		kind_t             kind;
		logic [SLOT_W-1:0] conn;
		logic              last;
		logic              empty;
	} event_t;

endpackage

// ===== src/ctq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ctq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/ctq_out.sv =====
// Output register stage for result beats.
`timescale 1ns / 1ps
module ctq_out (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push_valid,
	input  ctq_pkg::event_t        push_ev,
	output logic                   push_ready,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             event_kind,
	output logic [ctq_pkg::SLOT_W-1:0] event_conn,
	output logic                   last_event,
	output logic                   queue_empty
);
	import ctq_pkg::*;

	logic   valid_q;
	event_t ev_q;

	assign push_ready = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push_ready) begin
			valid_q <= push_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (push_ready && push_valid) begin
			ev_q <= push_ev;
		end
	end

	assign out_valid   = valid_q;
	assign event_kind  = ev_q.kind;
	assign event_conn  = ev_q.conn;
	assign last_event  = ev_q.last;
	assign queue_empty = ev_q.empty;

endmodule

// ===== src/ctq_ctrl.sv =====
// Command sequencer: list edits and timeout walk over the link and data memories.
`timescale 1ns / 1ps
module ctq_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [2:0]                  cmd,
	input  logic [ctq_pkg::SLOT_W-1:0]  conn_index,
	input  logic                        is_websocket,
	input  logic [ctq_pkg::BUMP_W-1:0]  bump,
	output logic                        nxt_we,
	output logic [ctq_pkg::ADDR_W-1:0]  nxt_waddr,
	output logic [ctq_pkg::LINK_W-1:0]  nxt_wdata,
	output logic                        nxt_re,
	output logic [ctq_pkg::ADDR_W-1:0]  nxt_raddr,
	input  logic [ctq_pkg::LINK_W-1:0]  nxt_rdata,
	output logic                        prv_we,
	output logic [ctq_pkg::ADDR_W-1:0]  prv_waddr,
	output logic [ctq_pkg::LINK_W-1:0]  prv_wdata,
	output logic                        prv_re,
	output logic [ctq_pkg::ADDR_W-1:0]  prv_raddr,
	input  logic [ctq_pkg::LINK_W-1:0]  prv_rdata,
	output logic                        dat_we,
	output logic [ctq_pkg::ADDR_W-1:0]  dat_waddr,
	output logic [ctq_pkg::DATA_W-1:0]  dat_wdata,
	output logic                        dat_re,
	output logic [ctq_pkg::ADDR_W-1:0]  dat_raddr,
	input  logic [ctq_pkg::DATA_W-1:0]  dat_rdata,
	output logic                        push_valid,
	output ctq_pkg::event_t             push_ev,
	input  logic                        push_ready
);
	import ctq_pkg::*;

	state_t              state_q, state_d;
	cmd_t                cmd_q, cmd_d;
	logic [SLOT_W-1:0]   slot_q, slot_d;
	logic                ping_q, ping_d;
	logic [TICK_W-1:0]   now_q, now_d;
	logic [LINK_W-1:0]   count_q, count_d;
	logic [LINK_W-1:0]   budget_q, budget_d;
	logic [LINK_W-1:0]   hf_q, hf_d;
	logic [LINK_W-1:0]   hl_q, hl_d;
	logic [CAPACITY-1:0] mark_q;
	logic                mark_set, mark_clr;
	event_t              hold_q, hold_d;
	logic                hold_v_q, hold_v_d;

	logic                slot_ok, in_marked, push_ok, do_emit;
	logic [ADDR_W-1:0]   in_addr, slot_addr;
	logic [TICK_W-1:0]   new_deadline;
	logic [LINK_W-1:0]   p_link, n_link;
	event_t              new_ev;

	assign in_addr      = conn_index[ADDR_W-1:0];
	assign slot_addr    = slot_q[ADDR_W-1:0];
	assign slot_ok      = {1'b0, conn_index} < LINK_W'(CAPACITY);
	assign in_marked    = mark_q[in_addr];
	assign new_deadline = now_q + TICK_W'(bump);
	assign push_ok      = !hold_v_q || push_ready;
	assign p_link       = prv_rdata;
	assign n_link       = nxt_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			now_q    <= '0;
			count_q  <= '0;
			hf_q     <= LINK_END;
			hl_q     <= LINK_END;
			mark_q   <= '0;
			hold_v_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			now_q    <= now_d;
			count_q  <= count_d;
			hf_q     <= hf_d;
			hl_q     <= hl_d;
			hold_v_q <= hold_v_d;
			if (mark_set) begin
				mark_q[slot_addr] <= 1'b1;
			end else if (mark_clr) begin
				mark_q[slot_addr] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmd_q    <= cmd_d;
		slot_q   <= slot_d;
		ping_q   <= ping_d;
		budget_q <= budget_d;
		hold_q   <= hold_d;
	end

	always_comb begin
		state_d   = state_q;
		cmd_d     = cmd_q;
		slot_d    = slot_q;
		ping_d    = ping_q;
		now_d     = now_q;
		count_d   = count_q;
		budget_d  = budget_q;
		hf_d      = hf_q;
		hl_d      = hl_q;
		hold_d    = hold_q;
		hold_v_d  = hold_v_q;
		mark_set  = 1'b0;
		mark_clr  = 1'b0;
		do_emit   = 1'b0;
		new_ev    = '0;
		nxt_we    = 1'b0;
		nxt_waddr = '0;
		nxt_wdata = '0;
		nxt_re    = 1'b0;
		nxt_raddr = '0;
		prv_we    = 1'b0;
		prv_waddr = '0;
		prv_wdata = '0;
		prv_re    = 1'b0;
		prv_raddr = '0;
		dat_we    = 1'b0;
		dat_waddr = '0;
		dat_wdata = '0;
		dat_re    = 1'b0;
		dat_raddr = '0;
		push_valid = 1'b0;
		push_ev    = '0;
		in_stall   = (state_q != S_IDLE);

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd_d    = cmd_t'(cmd);
					slot_d   = conn_index;
					ping_d   = 1'b0;
					hold_v_d = 1'b0;
					hold_d.kind  = EV_REJECT;
					hold_d.conn  = conn_index;
					hold_d.last  = 1'b0;
					hold_d.empty = (hf_q == LINK_END);
					state_d  = S_FIN;
					unique case (cmd_t'(cmd))
						CMD_INSERT: begin
							if (!slot_ok || in_marked) begin
								hold_v_d = 1'b1;
							end else begin
								dat_we    = 1'b1;
								dat_waddr = in_addr;
								dat_wdata = {new_deadline, is_websocket};
								state_d   = S_APP1;
							end
						end
						CMD_TOUCH, CMD_CLOSE: begin
							if (!slot_ok || !in_marked) begin
								hold_v_d = 1'b1;
							end else begin
								if (cmd_t'(cmd) == CMD_TOUCH) begin
									dat_we    = 1'b1;
									dat_waddr = in_addr;
									dat_wdata = {new_deadline, is_websocket};
								end
								nxt_re    = 1'b1;
								nxt_raddr = in_addr;
								prv_re    = 1'b1;
								prv_raddr = in_addr;
								state_d   = S_UNL;
							end
						end
						CMD_TICK: begin
							now_d    = now_q + TICK_W'(1);
							budget_d = count_q;
							state_d  = S_WALK;
						end
						CMD_CLOSE_ALL: begin
							state_d = S_WALK;
						end
						default: begin
							hold_v_d = 1'b1;
						end
					endcase
				end
			end
			S_WALK: begin
				if (hf_q == LINK_END || (cmd_q == CMD_TICK && budget_q == '0)) begin
					state_d = S_FIN;
				end else begin
					nxt_re    = 1'b1;
					nxt_raddr = hf_q[ADDR_W-1:0];
					prv_re    = 1'b1;
					prv_raddr = hf_q[ADDR_W-1:0];
					dat_re    = 1'b1;
					dat_raddr = hf_q[ADDR_W-1:0];
					slot_d    = hf_q[SLOT_W-1:0];
					budget_d  = budget_q - LINK_W'(1);
					state_d   = S_CHK;
				end
			end
			S_CHK: begin
				ping_d  = 1'b0;
				state_d = S_UNL;
				if (cmd_q == CMD_TICK) begin
					if (dat_rdata[DATA_W-1:1] > now_q) begin
						state_d = S_FIN;
					end else if (dat_rdata[0]) begin
						dat_we    = 1'b1;
						dat_waddr = slot_addr;
						dat_wdata = {new_deadline, 1'b1};
						ping_d    = 1'b1;
					end
				end
			end
			S_UNL: begin
				if ((cmd_q == CMD_TOUCH || ping_q) || push_ok) begin
					if (p_link == LINK_END) begin
						hf_d = n_link;
					end else begin
						nxt_we    = 1'b1;
						nxt_waddr = p_link[ADDR_W-1:0];
						nxt_wdata = n_link;
					end
					if (n_link == LINK_END) begin
						hl_d = p_link;
					end else begin
						prv_we    = 1'b1;
						prv_waddr = n_link[ADDR_W-1:0];
						prv_wdata = p_link;
					end
					if (cmd_q == CMD_TOUCH || ping_q) begin
						state_d = S_APP1;
					end else begin
						mark_clr     = 1'b1;
						count_d      = count_q - LINK_W'(1);
						do_emit      = 1'b1;
						new_ev.kind  = EV_EXPIRED;
						new_ev.conn  = slot_q;
						new_ev.empty = (p_link == LINK_END) ? (n_link == LINK_END)
						                                    : (hf_q == LINK_END);
						state_d      = (cmd_q == CMD_CLOSE) ? S_FIN : S_WALK;
					end
				end
			end
			S_APP1: begin
				nxt_we    = 1'b1;
				nxt_waddr = slot_addr;
				nxt_wdata = LINK_END;
				prv_we    = 1'b1;
				prv_waddr = slot_addr;
				prv_wdata = hl_q;
				state_d   = S_APP2;
			end
			S_APP2: begin
				if (!ping_q || push_ok) begin
					if (hl_q == LINK_END) begin
						hf_d = {1'b0, slot_q};
					end else begin
						nxt_we    = 1'b1;
						nxt_waddr = hl_q[ADDR_W-1:0];
						nxt_wdata = {1'b0, slot_q};
					end
					hl_d = {1'b0, slot_q};
					if (cmd_q == CMD_INSERT) begin
						mark_set = 1'b1;
						count_d  = count_q + LINK_W'(1);
					end
					if (ping_q) begin
						do_emit      = 1'b1;
						new_ev.kind  = EV_PING;
						new_ev.conn  = slot_q;
						new_ev.empty = 1'b0;
						state_d      = S_WALK;
					end else begin
						state_d = S_FIN;
					end
				end
			end
			S_FIN: begin
				if (push_ready) begin
					push_valid = 1'b1;
					if (hold_v_q) begin
						push_ev      = hold_q;
						push_ev.last = 1'b1;
					end else begin
						push_ev.kind  = EV_DONE;
						push_ev.conn  = '0;
						push_ev.last  = 1'b1;
						push_ev.empty = (hf_q == LINK_END);
					end
					hold_v_d = 1'b0;
					if (cmd_q == CMD_TICK && hf_q == LINK_END) begin
						now_d = '0;
					end
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// Release the held beat once a newer one exists; it is then not the last.
		if (do_emit) begin
			if (hold_v_q) begin
				push_valid = 1'b1;
				push_ev    = hold_q;
			end
			hold_d   = new_ev;
			hold_v_d = 1'b1;
		end
	end

endmodule

// ===== src/connection_idle_timeout_queue.sv =====
// Top level of the connection idle timeout queue.
`timescale 1ns / 1ps
// Connection idle timeout queue.
// Input channel (in_valid / in_stall) carries one command beat: insert, touch,
// close one, tick or close all, with a connection slot and a websocket flag.
// Output channel (out_valid / out_stall) returns result beats; last_event
// marks the final beat of a command, and every command gives at least one.
// The keep-alive bump is to be written through cfg_wr_en / cfg_wr_data while idle; the block does not enforce this.
// Commands are handled one at a time by a sequencer over three memories
// with registered read data (next links, previous links, deadline plus websocket flag).
// Each beat is held back one step so that its last flag is known, then goes
// to an output register: a stalled receiver freezes the sequencer only when
// a further beat must be handed over.
// Reset empties the list, clears the queued marks, zeroes time and sets the
// bump to 15; memory contents are left as they are and never read unwritten.
module connection_idle_timeout_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [ctq_pkg::BUMP_W-1:0] cfg_wr_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [2:0]                 cmd,
	input  logic [ctq_pkg::SLOT_W-1:0] conn_index,
	input  logic                       is_websocket,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [1:0]                 event_kind,
	output logic [ctq_pkg::SLOT_W-1:0] event_conn,
	output logic                       last_event,
	output logic                       queue_empty
);
	import ctq_pkg::*;

	logic [BUMP_W-1:0] bump_q;

	logic              nxt_we, nxt_re, prv_we, prv_re, dat_we, dat_re;
	logic [ADDR_W-1:0] nxt_waddr, nxt_raddr, prv_waddr, prv_raddr, dat_waddr, dat_raddr;
	logic [LINK_W-1:0] nxt_wdata, nxt_rdata, prv_wdata, prv_rdata;
	logic [DATA_W-1:0] dat_wdata, dat_rdata;
	logic              push_valid, push_ready;
	event_t            push_ev;

	// Holds the keep-alive bump, to be written only while no command is in flight; unchecked by the block.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bump_q <= BUMP_RESET;
		end else if (cfg_wr_en) begin
			bump_q <= cfg_wr_data;
		end
	end

	// Next-link store.
	ctq_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_next_ram (
		.clk   (clk),
		.we    (nxt_we),
		.waddr (nxt_waddr),
		.wdata (nxt_wdata),
		.re    (nxt_re),
		.raddr (nxt_raddr),
		.rdata (nxt_rdata)
	);

	// Previous-link store.
	ctq_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_prev_ram (
		.clk   (clk),
		.we    (prv_we),
		.waddr (prv_waddr),
		.wdata (prv_wdata),
		.re    (prv_re),
		.raddr (prv_raddr),
		.rdata (prv_rdata)
	);

	// Deadline with the websocket flag in the low bit.
	ctq_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_data_ram (
		.clk   (clk),
		.we    (dat_we),
		.waddr (dat_waddr),
		.wdata (dat_wdata),
		.re    (dat_re),
		.raddr (dat_raddr),
		.rdata (dat_rdata)
	);

	ctq_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.conn_index   (conn_index),
		.is_websocket (is_websocket),
		.bump         (bump_q),
		.nxt_we       (nxt_we),
		.nxt_waddr    (nxt_waddr),
		.nxt_wdata    (nxt_wdata),
		.nxt_re       (nxt_re),
		.nxt_raddr    (nxt_raddr),
		.nxt_rdata    (nxt_rdata),
		.prv_we       (prv_we),
		.prv_waddr    (prv_waddr),
		.prv_wdata    (prv_wdata),
		.prv_re       (prv_re),
		.prv_raddr    (prv_raddr),
		.prv_rdata    (prv_rdata),
		.dat_we       (dat_we),
		.dat_waddr    (dat_waddr),
		.dat_wdata    (dat_wdata),
		.dat_re       (dat_re),
		.dat_raddr    (dat_raddr),
		.dat_rdata    (dat_rdata),
		.push_valid   (push_valid),
		.push_ev      (push_ev),
		.push_ready   (push_ready)
	);

	// Output register: parts the sequencer from the receiver.
	ctq_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.push_valid  (push_valid),
		.push_ev     (push_ev),
		.push_ready  (push_ready),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.event_kind  (event_kind),
		.event_conn  (event_conn),
		.last_event  (last_event),
		.queue_empty (queue_empty)
	);

endmodule

// ===== src/ctq_checker.sv =====
// Port-level checker for the connection idle timeout queue, with its bind.
`timescale 1ns / 1ps
module ctq_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] event_kind,
	input logic [5:0] event_conn,
	input logic       last_event,
	input logic       queue_empty
);
	import ctq_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second command taken while one is in flight");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == EV_DONE |-> last_event)
		else $error("done beat not marked last");

	a_done_conn: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == EV_DONE |-> event_conn == 6'd0)
		else $error("done beat carries a slot");

	a_ping_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == EV_PING |-> !queue_empty)
		else $error("ping beat reports an empty queue");

endmodule

bind connection_idle_timeout_queue ctq_checker u_ctq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.event_kind  (event_kind),
	.event_conn  (event_conn),
	.last_event  (last_event),
	.queue_empty (queue_empty)
);

// ===== sim/connection_idle_timeout_queue_tb.sv =====
// Self-checking testbench for the connection idle timeout queue.
`timescale 1ns / 1ps
module connection_idle_timeout_queue_tb;
	import ctq_pkg::*;

	// One command beat as offered on the input channel.
	typedef struct packed {
		logic [2:0]        op;
		logic [SLOT_W-1:0] slot;
		logic              ws;
	} beat_t;

	localparam int STALL_LIMIT = 5000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic [BUMP_W-1:0]   cfg_wr_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [2:0]          cmd = '0;
	logic [SLOT_W-1:0]   conn_index = '0;
	logic                is_websocket = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [1:0]          event_kind;
	logic [SLOT_W-1:0]   event_conn;
	logic                last_event;
	logic                queue_empty;

	connection_idle_timeout_queue u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.conn_index   (conn_index),
		.is_websocket (is_websocket),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.event_kind   (event_kind),
		.event_conn   (event_conn),
		.last_event   (last_event),
		.queue_empty  (queue_empty)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the list state, kept in step with accepted beats.
	logic [LINK_W-1:0] nxt_link [CAPACITY];
	logic [LINK_W-1:0] prv_link [CAPACITY];
	logic [TICK_W-1:0] due_tick [CAPACITY];
	bit                ws_flag  [CAPACITY];
	bit                in_list  [CAPACITY];
	logic [LINK_W-1:0] list_head = LINK_END;
	logic [LINK_W-1:0] list_tail = LINK_END;
	logic [TICK_W-1:0] now_tick = '0;
	int unsigned       list_len = 0;
	logic [BUMP_W-1:0] bump = BUMP_RESET;

	event_t pending_events [$];
	beat_t  cmd_backlog [$];
	event_t held_event;
	bit     have_held;

	// Handshake bookkeeping: counters and flags written and read across processes.
	int unsigned cmds_offered = 0;
	int unsigned cmds_accepted = 0;
	int unsigned events_taken = 0;
	int unsigned long_hold_req = 0;
	int          err_count = 0;
	int unsigned quiet_cycles = 0;
	bit          tx_no_gap = 0;

	// Hold back each event one step so the last one of a command can be flagged.
	task automatic post_event(kind_t kind, logic [SLOT_W-1:0] slot);
		if (have_held)
			pending_events.push_back(held_event);
		held_event.kind  = kind;
		held_event.conn  = slot;
		held_event.last  = 1'b0;
		held_event.empty = (list_head == LINK_END);
		have_held = 1;
	endtask

	task automatic unlink_slot(logic [SLOT_W-1:0] s);
		logic [LINK_W-1:0] p;
		logic [LINK_W-1:0] n;
		p = prv_link[s];
		n = nxt_link[s];
		if (p == LINK_END) list_head = n; else nxt_link[p[SLOT_W-1:0]] = n;
		if (n == LINK_END) list_tail = p; else prv_link[n[SLOT_W-1:0]] = p;
	endtask

	task automatic append_slot(logic [SLOT_W-1:0] s);
		nxt_link[s] = LINK_END;
		prv_link[s] = list_tail;
		if (list_tail == LINK_END) list_head = {1'b0, s};
		else nxt_link[list_tail[SLOT_W-1:0]] = {1'b0, s};
		list_tail = {1'b0, s};
	endtask

	// Apply one accepted command to the shadow list and queue the events it yields.
	task automatic model_command(beat_t b);
		int unsigned       budget;
		logic [SLOT_W-1:0] h;
		bit                walking;
		have_held = 0;
		case (b.op)
			CMD_INSERT: begin
				if (in_list[b.slot]) begin
					post_event(EV_REJECT, b.slot);
				end else begin
					due_tick[b.slot] = now_tick + bump;
					ws_flag[b.slot] = b.ws;
					append_slot(b.slot);
					in_list[b.slot] = 1;
					list_len++;
					post_event(EV_DONE, '0);
				end
			end
			CMD_TOUCH: begin
				if (!in_list[b.slot]) begin
					post_event(EV_REJECT, b.slot);
				end else begin
					due_tick[b.slot] = now_tick + bump;
					ws_flag[b.slot] = b.ws;
					unlink_slot(b.slot);
					append_slot(b.slot);
					post_event(EV_DONE, '0);
				end
			end
			CMD_CLOSE: begin
				if (!in_list[b.slot]) begin
					post_event(EV_REJECT, b.slot);
				end else begin
					unlink_slot(b.slot);
					in_list[b.slot] = 0;
					list_len--;
					post_event(EV_EXPIRED, b.slot);
				end
			end
			CMD_TICK: begin
				// Examine no more entries than were queued when the tick began.
				budget = list_len;
				now_tick = now_tick + 1;
				walking = 1;
				while (walking && list_head != LINK_END && budget > 0) begin
					h = list_head[SLOT_W-1:0];
					budget--;
					if (due_tick[h] > now_tick) begin
						walking = 0;
					end else if (ws_flag[h]) begin
						due_tick[h] = now_tick + bump;
						unlink_slot(h);
						append_slot(h);
						post_event(EV_PING, h);
					end else begin
						unlink_slot(h);
						in_list[h] = 0;
						list_len--;
						post_event(EV_EXPIRED, h);
					end
				end
				if (list_head == LINK_END) now_tick = '0;
				if (!have_held) post_event(EV_DONE, '0);
			end
			CMD_CLOSE_ALL: begin
				while (list_head != LINK_END) begin
					h = list_head[SLOT_W-1:0];
					unlink_slot(h);
					in_list[h] = 0;
					list_len--;
					post_event(EV_EXPIRED, h);
				end
				if (!have_held) post_event(EV_DONE, '0);
			end
			default: post_event(EV_REJECT, b.slot);
		endcase
		held_event.last = 1'b1;
		pending_events.push_back(held_event);
	endtask

	// Rising edge: take beats on both channels, check results, watch for a hang.
	always @(posedge clk) begin
		event_t want;
		bit     moved;
		if (arst_n) begin
			moved = 0;
			if (in_valid && !in_stall) begin
				model_command('{cmd, conn_index, is_websocket});
				cmds_accepted <= cmds_accepted + 1;
				moved = 1;
			end
			if (out_valid && !out_stall) begin
				moved = 1;
				events_taken <= events_taken + 1;
				if (pending_events.size() == 0) begin
					$error("unexpected event kind=%0d conn=%0d", event_kind, event_conn);
					err_count++;
				end else begin
					want = pending_events.pop_front();
					if (event_kind !== want.kind) begin
						$error("event_kind: expected %0d, got %0d", want.kind, event_kind);
						err_count++;
					end
					if (event_conn !== want.conn) begin
						$error("event_conn: expected %0d, got %0d", want.conn, event_conn);
						err_count++;
					end
					if (last_event !== want.last) begin
						$error("last_event: expected %0d, got %0d", want.last, last_event);
						err_count++;
					end
					if (queue_empty !== want.empty) begin
						$error("queue_empty: expected %0d, got %0d", want.empty, queue_empty);
						err_count++;
					end
				end
			end
			quiet_cycles <= moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("connection_idle_timeout_queue_tb: FAIL");
				$finish;
			end
		end
	end

	// Command driver: advance to the next backlog beat once the current one is taken.
	int unsigned tx_gap = 0;
	int unsigned tx_sent = 0;
	always @(negedge clk) begin
		beat_t b;
		if (arst_n && !(in_valid && tx_sent != cmds_accepted)) begin
			if (tx_gap > 0) begin
				tx_gap <= tx_gap - 1;
				in_valid <= 1'b0;
			end else if (cmd_backlog.size() > 0) begin
				b = cmd_backlog.pop_front();
				cmd <= b.op;
				conn_index <= b.slot;
				is_websocket <= b.ws;
				in_valid <= 1'b1;
				tx_sent = tx_sent + 1;
				cmds_offered <= tx_sent;
				// Leave runs of back-to-back beats now and then.
				if (tx_no_gap || $urandom_range(0, 3) == 0) tx_gap <= 0;
				else tx_gap <= $urandom_range(0, 15);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result receiver: stall a random count per beat, or a long stretch on request.
	int unsigned rx_wait = 0;
	int unsigned rx_seen = 0;
	int unsigned rx_long_done = 0;
	always @(negedge clk) begin
		int unsigned w;
		w = rx_wait;
		if (rx_long_done != long_hold_req) begin
			rx_long_done <= long_hold_req;
			w = 400;
		end else if (rx_seen != events_taken) begin
			rx_seen <= events_taken;
			w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
		end
		if (w > 0) begin
			out_stall <= 1'b1;
			rx_wait <= w - 1;
		end else begin
			out_stall <= 1'b0;
			rx_wait <= 0;
		end
	end

	task automatic push_cmd(logic [2:0] op, logic [SLOT_W-1:0] slot, logic ws);
		cmd_backlog.push_back('{op, slot, ws});
	endtask

	// Mostly well-formed traffic on a few busy slots, plus ticks to age them.
	function automatic beat_t random_beat();
		beat_t b;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		b.slot = ($urandom_range(0, 4) == 0) ? SLOT_W'($urandom_range(0, 63))
			: SLOT_W'($urandom_range(0, 15));
		b.ws = 1'($urandom_range(0, 1));
		if (pick < 32) b.op = CMD_INSERT;
		else if (pick < 47) b.op = CMD_TOUCH;
		else if (pick < 57) b.op = CMD_CLOSE;
		else if (pick < 94) b.op = CMD_TICK;
		else if (pick < 97) b.op = CMD_CLOSE_ALL;
		else b.op = 3'($urandom_range(5, 7));
		return b;
	endfunction

	// Wait until every beat is taken and every result is in, then let the block settle.
	task automatic drain();
		while (cmd_backlog.size() != 0 || cmds_offered != cmds_accepted
			|| in_valid || pending_events.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_bump(logic [BUMP_W-1:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		bump = value;
	endtask

	initial begin
		logic [BUMP_W-1:0] phase_bump [6];
		phase_bump = '{16'd1, 16'd65535, 16'd2, 16'd3, 16'd15, 16'd1};
		for (int i = 0; i < CAPACITY; i++) in_list[i] = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset bump: rejects, unknown codes, touch and closes.
		push_cmd(CMD_TICK, 6'd0, 1'b0);
		push_cmd(CMD_INSERT, 6'd0, 1'b0);
		push_cmd(CMD_INSERT, 6'd63, 1'b1);
		push_cmd(CMD_INSERT, 6'd0, 1'b1);
		push_cmd(CMD_TOUCH, 6'd5, 1'b0);
		push_cmd(CMD_CLOSE, 6'd7, 1'b1);
		push_cmd(3'd5, 6'd63, 1'b1);
		push_cmd(3'd6, 6'd0, 1'b0);
		push_cmd(3'd7, 6'd42, 1'b1);
		push_cmd(CMD_TOUCH, 6'd63, 1'b0);
		push_cmd(CMD_TOUCH, 6'd63, 1'b1);
		push_cmd(CMD_CLOSE, 6'd0, 1'b0);
		push_cmd(CMD_INSERT, 6'd0, 1'b0);
		push_cmd(CMD_CLOSE_ALL, 6'd0, 1'b0);
		push_cmd(CMD_CLOSE_ALL, 6'd21, 1'b1);
		drain();

		// Smallest bump: a websocket pings and requeues, a plain slot expires.
		write_bump(16'd1);
		push_cmd(CMD_INSERT, 6'd1, 1'b1);
		push_cmd(CMD_TICK, 6'd0, 1'b0);
		push_cmd(CMD_INSERT, 6'd2, 1'b0);
		push_cmd(CMD_TICK, 6'd0, 1'b0);
		push_cmd(CMD_TICK, 6'd0, 1'b0);
		push_cmd(CMD_CLOSE_ALL, 6'd0, 1'b0);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			write_bump((ph == 4) ? BUMP_W'($urandom_range(1, 65535)) : phase_bump[ph]);
			if (ph == 2) begin
				// Hold the result side off while the sender keeps offering beats.
				tx_no_gap = 1;
				long_hold_req = long_hold_req + 1;
			end
			for (int i = 0; i < 33; i++) cmd_backlog.push_back(random_beat());
			if (ph == 5) push_cmd(CMD_CLOSE_ALL, 6'd0, 1'b0);
			drain();
			tx_no_gap = 0;
		end

		if (err_count == 0)
			$display("connection_idle_timeout_queue_tb: PASS");
		else
			$display("connection_idle_timeout_queue_tb: FAIL");
		$finish;
	end

endmodule
